[rtl/lsfs_pkg.sv]
package lsfs_pkg;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_LEDS  = 2'd2,
    PH_END   = 2'd3
  } phase_e;

  typedef struct packed {
    op_e         op;
    logic [23:0] colour;
  } cmd_t;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic busy_res;
    logic accepted;
  } res_t;

  localparam logic [7:0] ByteZero     = 8'h00;
  localparam logic [7:0] ByteOnes     = 8'hFF;
  localparam logic [3:0] LastStartIdx = 4'd3;
  localparam logic [3:0] LastLedIdx   = 4'd3;
  localparam logic [2:0] LastBitIdx   = 3'd7;
  localparam logic [7:0] CountReset   = 8'd16;

endpackage

[rtl/lsfs_fifo.sv]
module lsfs_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/lsfs_front.sv]
module lsfs_front
  import lsfs_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       action_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  localparam int CmdW = $bits(cmd_t);

  cmd_t            cmd_in;
  logic [CmdW-1:0] cmd_raw;
  logic            cmd_empty;

  // Classify the word; ticks carry no colour.
  always_comb begin
    cmd_in.op     = action_i ? OP_REQUEST : OP_TICK;
    cmd_in.colour = action_i ? {red_i, green_i, blue_i} : 24'd0;
  end

  lsfs_fifo #(
    .Width(CmdW),
    .Depth(Depth)
  ) u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (push),
    .wr_data_i(cmd_in),
    .full_o   (full),
    .rd_en_i  (cmd_pop_i),
    .rd_data_o(cmd_raw),
    .empty_o  (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;
  assign cmd_o       = cmd_t'(cmd_raw);

endmodule

[rtl/lsfs_engine.sv]
module lsfs_engine
  import lsfs_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  input  logic [7:0] led_count_i,
  output logic       empty,
  input  logic       pop,
  output res_t       res_o
);

  localparam int ResW = $bits(res_t);

  phase_e      phase_q, phase_d;
  logic [7:0]  led_q, led_d;
  logic [3:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  logic        half_q, half_d;
  logic [23:0] colour_q, colour_d;
  logic        clk_q, clk_d;
  logic        data_q, data_d;

  logic            res_full;
  logic            step;
  logic            took;
  logic [4:0]      end_bytes;
  logic [8:0]      led_nxt;
  logic [7:0]      cur_byte;
  res_t            res_in;
  logic [ResW-1:0] res_raw;

  assign step      = cmd_valid_i && !res_full;
  assign cmd_pop_o = step;
  assign end_bytes = 5'(({1'b0, led_count_i} + 9'd15) >> 4);
  assign led_nxt   = {1'b0, led_q} + 9'd1;

  always_comb begin
    case (phase_q)
      PH_START: cur_byte = ByteZero;
      PH_LEDS: begin
        case (byte_q[1:0])
          2'd0:    cur_byte = ByteOnes;
          2'd1:    cur_byte = colour_q[23:16];
          2'd2:    cur_byte = colour_q[15:8];
          default: cur_byte = colour_q[7:0];
        endcase
      end
      default: cur_byte = ByteOnes;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    led_d    = led_q;
    byte_d   = byte_q;
    bit_d    = bit_q;
    half_d   = half_q;
    colour_d = colour_q;
    clk_d    = clk_q;
    data_d   = data_q;
    took     = 1'b0;
    if (step) begin
      if (cmd_i.op == OP_REQUEST) begin
        // Drop a request while a frame is in flight.
        if (phase_q == PH_IDLE) begin
          colour_d = cmd_i.colour;
          phase_d  = PH_START;
          led_d    = '0;
          byte_d   = '0;
          bit_d    = '0;
          half_d   = 1'b0;
          took     = 1'b1;
        end
      end else if (phase_q != PH_IDLE) begin
        if (!half_q) begin
          clk_d  = 1'b0;
          data_d = cur_byte[LastBitIdx - bit_q];
          half_d = 1'b1;
        end else begin
          clk_d  = 1'b1;
          half_d = 1'b0;
          if (bit_q == LastBitIdx) begin
            bit_d = '0;
            case (phase_q)
              PH_START: begin
                if (byte_q >= LastStartIdx) begin
                  byte_d = '0;
                  led_d  = '0;
                  if (led_count_i == 8'd0) begin
                    phase_d = PH_IDLE;
                    data_d  = 1'b1;
                  end else begin
                    phase_d = PH_LEDS;
                  end
                end else begin
                  byte_d = byte_q + 4'd1;
                end
              end
              PH_LEDS: begin
                if (byte_q >= LastLedIdx) begin
                  byte_d = '0;
                  led_d  = led_nxt[7:0];
                  // Count is read live; a wrap past the top also ends the LED frames.
                  if (led_nxt[8] || (led_nxt[7:0] >= led_count_i)) begin
                    if (end_bytes == 5'd0) begin
                      phase_d = PH_IDLE;
                      data_d  = 1'b1;
                    end else begin
                      phase_d = PH_END;
                    end
                  end
                end else begin
                  byte_d = byte_q + 4'd1;
                end
              end
              PH_END: begin
                if (({1'b0, byte_q} + 5'd1) >= end_bytes) begin
                  phase_d = PH_IDLE;
                  byte_d  = '0;
                  data_d  = 1'b1;
                end else begin
                  byte_d = byte_q + 4'd1;
                end
              end
              default: begin
                phase_d = PH_IDLE;
              end
            endcase
          end else begin
            bit_d = bit_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      led_q    <= '0;
      byte_q   <= '0;
      bit_q    <= '0;
      half_q   <= 1'b0;
      colour_q <= '0;
      clk_q    <= 1'b1;
      data_q   <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      led_q    <= led_d;
      byte_q   <= byte_d;
      bit_q    <= bit_d;
      half_q   <= half_d;
      colour_q <= colour_d;
      clk_q    <= clk_d;
      data_q   <= data_d;
    end
  end

  always_comb begin
    res_in.clock_line = clk_d;
    res_in.data_line  = data_d;
    res_in.busy_res   = (phase_d != PH_IDLE);
    res_in.accepted   = took;
  end

  lsfs_fifo #(
    .Width(ResW),
    .Depth(Depth)
  ) u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (step),
    .wr_data_i(res_in),
    .full_o   (res_full),
    .rd_en_i  (pop),
    .rd_data_o(res_raw),
    .empty_o  (empty)
  );

  assign res_o = res_t'(res_raw);

endmodule

[rtl/led_strip_frame_serializer.sv]
// Channel   Handshake              Payload
// input     push / full            action_i, red_i, green_i, blue_i
// result    empty / pop            clock_line_o, data_line_o, busy_res_o, accepted_o
// config    cfg_we_i               cfg_wdata_i (led count)
//
// One word in and one word out per cycle when neither side stalls; the line
// engine retires one command a cycle while the result queue has room. A taken
// push reaches the ports through one register in each queue (QueueDepth words each).
// Reset clears both queues, idles the engine with both lines high and sets the
// led count to 16. A stalled result side fills the result queue, then the
// command queue, and only then raises full.
module led_strip_frame_serializer
  import lsfs_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       action_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       empty,
  input  logic       pop,
  output logic       clock_line_o,
  output logic       data_line_o,
  output logic       busy_res_o,
  output logic       accepted_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic [7:0] led_count_q;
  logic       cmd_valid;
  logic       cmd_pop;
  cmd_t       cmd;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= CountReset;
    end else if (cfg_we_i) begin
      led_count_q <= cfg_wdata_i;
    end
  end

  lsfs_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .action_i   (action_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  lsfs_engine #(
    .Depth(QueueDepth)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .led_count_i(led_count_q),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res)
  );

  assign clock_line_o = res.clock_line;
  assign data_line_o  = res.data_line;
  assign busy_res_o   = res.busy_res;
  assign accepted_o   = res.accepted;

endmodule

[tb/led_strip_frame_serializer_tb.sv]
module led_strip_frame_serializer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsfs_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int RandomWords = 500;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic       action_i;
  logic [7:0] red_i;
  logic [7:0] green_i;
  logic [7:0] blue_i;
  logic       empty;
  logic       pop;
  logic       clock_line_o;
  logic       data_line_o;
  logic       busy_res_o;
  logic       accepted_o;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  // line predictor state
  phase_e      ph;
  logic [7:0]  led_idx;
  logic [3:0]  byte_idx;
  logic [2:0]  bit_idx;
  logic        half;
  logic [23:0] held;
  logic        clk_lvl;
  logic        dat_lvl;
  logic [7:0]  led_count_q;

  res_t line_q[$];
  int   n_errors;
  int   n_busy_words;
  int   n_cycles;
  bit   gaps_on;

  led_strip_frame_serializer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .empty       (empty),
    .pop         (pop),
    .clock_line_o(clock_line_o),
    .data_line_o (data_line_o),
    .busy_res_o  (busy_res_o),
    .accepted_o  (accepted_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int trailer_bytes();
    return (int'(led_count_q) + 15) / 16;
  endfunction

  function automatic logic [7:0] byte_now();
    if (ph == PH_START) return ByteZero;
    if (ph == PH_LEDS) begin
      case (byte_idx[1:0])
        2'd0: return ByteOnes;
        2'd1: return held[23:16];
        2'd2: return held[15:8];
        default: return held[7:0];
      endcase
    end
    return ByteOnes;
  endfunction

  function automatic void finish_leds();
    byte_idx = '0;
    if (trailer_bytes() == 0) begin
      ph = PH_IDLE;
      dat_lvl = 1'b1;
    end else begin
      ph = PH_END;
    end
  endfunction

  function automatic void advance_byte();
    case (ph)
      PH_START: begin
        if (byte_idx >= LastStartIdx) begin
          byte_idx = '0;
          led_idx = '0;
          if (led_count_q == 8'd0) finish_leds();
          else ph = PH_LEDS;
        end else begin
          byte_idx++;
        end
      end
      PH_LEDS: begin
        if (byte_idx >= LastLedIdx) begin
          byte_idx = '0;
          led_idx++;
          // the count is read live, so a lowered count ends the LED frames here
          if (led_idx >= led_count_q || led_idx == 8'd0) finish_leds();
        end else begin
          byte_idx++;
        end
      end
      PH_END: begin
        if (int'(byte_idx) + 1 >= trailer_bytes()) begin
          ph = PH_IDLE;
          byte_idx = '0;
          dat_lvl = 1'b1;
        end else begin
          byte_idx++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic res_t step_line(op_e op, logic [23:0] colour);
    res_t r;
    logic [7:0] cur;
    r.accepted = 1'b0;
    if (op == OP_REQUEST) begin
      if (ph == PH_IDLE) begin
        held = colour;
        ph = PH_START;
        led_idx = '0;
        byte_idx = '0;
        bit_idx = '0;
        half = 1'b0;
        r.accepted = 1'b1;
      end
    end else if (ph != PH_IDLE) begin
      if (!half) begin
        cur = byte_now();
        clk_lvl = 1'b0;
        dat_lvl = cur[LastBitIdx - bit_idx];
        half = 1'b1;
      end else begin
        clk_lvl = 1'b1;
        half = 1'b0;
        if (bit_idx == LastBitIdx) begin
          bit_idx = '0;
          advance_byte();
        end else begin
          bit_idx++;
        end
      end
    end
    r.clock_line = clk_lvl;
    r.data_line = dat_lvl;
    r.busy_res = (ph != PH_IDLE);
    return r;
  endfunction

  task automatic flag(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) flag($sformatf("%s got %b, expected %b", name, got, want));
  endtask

  task automatic send_word(input op_e op, input logic [23:0] colour);
    int gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push     <= 1'b1;
    action_i <= op;
    red_i    <= colour[23:16];
    green_i  <= colour[15:8];
    blue_i   <= colour[7:0];
    do @(posedge clk_i); while (full !== 1'b0);
    if ((op == OP_TICK && ph != PH_IDLE) || (op == OP_REQUEST && ph == PH_IDLE))
      n_busy_words++;
    line_q.push_back(step_line(op, colour));
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 24'($urandom()));
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick();
  endtask

  task automatic run_to_idle();
    while (ph != PH_IDLE) send_tick();
  endtask

  task automatic run_to_end_bytes();
    while (ph != PH_END) send_tick();
  endtask

  // hold the sender until every result word is back
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (line_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [7:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    led_count_q = v;
  endtask

  initial begin : result_side
    int hold;
    res_t got;
    res_t want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        got.clock_line = clock_line_o;
        got.data_line  = data_line_o;
        got.busy_res   = busy_res_o;
        got.accepted   = accepted_o;
        if (line_q.size() == 0) begin
          flag("result word with none expected");
        end else begin
          want = line_q.pop_front();
          check_field("clock_line", got.clock_line, want.clock_line);
          check_field("data_line", got.data_line, want.data_line);
          check_field("busy_res", got.busy_res, want.busy_res);
          check_field("accepted", got.accepted, want.accepted);
        end
        hold = gaps_on ? $urandom_range(0, 12) : 0;
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    n_cycles = 0;
    while (n_cycles < CycleLimit) begin
      @(posedge clk_i);
      n_cycles++;
    end
    $display("timeout after %0d cycles", n_cycles);
    $display("TEST FAILED");
    $finish;
  end

  task automatic test_idle_ticks();
    run_ticks(4);
  endtask

  // zero LEDs: only the start frame goes out
  task automatic test_start_only();
    write_count(8'd0);
    send_word(OP_REQUEST, 24'hFFFFFF);
    run_ticks(20);
    send_word(OP_REQUEST, 24'h123456);
    run_to_idle();
    run_ticks(2);
  endtask

  task automatic test_colour_extremes();
    write_count(8'd1);
    send_word(OP_REQUEST, 24'h000000);
    run_to_idle();
    send_word(OP_REQUEST, 24'hFFFFFF);
    run_to_idle();
    send_word(OP_REQUEST, 24'h8001A5);
    run_to_idle();
  endtask

  task automatic test_busy_request();
    write_count(8'd2);
    send_word(OP_REQUEST, 24'h5A3C96);
    run_ticks(11);
    send_word(OP_REQUEST, 24'hA5C369);
    run_to_idle();
    // straight back in once idle
    send_word(OP_REQUEST, 24'h0F0F0F);
    run_to_idle();
  endtask

  task automatic test_count_change_midframe();
    write_count(8'd4);
    send_word(OP_REQUEST, 24'hC0FFEE);
    run_ticks(64 + 2 * 64 + 5);
    write_count(8'd1);
    run_to_idle();
    write_count(8'd3);
    send_word(OP_REQUEST, 24'h1E2D3C);
    run_ticks(64 + 16);
    write_count(8'd40);
    run_ticks(64 * 4 + 7);
    write_count(8'd0);
    run_to_idle();
  endtask

  // the end-byte count is read live, so raise it once the end bytes start
  task automatic test_end_byte_counts();
    write_count(8'd1);
    send_word(OP_REQUEST, 24'h7F80FE);
    run_to_end_bytes();
    write_count(8'd16);
    run_to_idle();
    write_count(8'd1);
    send_word(OP_REQUEST, 24'h017F80);
    run_to_end_bytes();
    write_count(8'd17);
    run_to_idle();
  endtask

  // top count: sixteen end bytes, the byte index runs to its last value
  task automatic test_top_count();
    gaps_on = 1'b0;
    write_count(8'd1);
    send_word(OP_REQUEST, 24'($urandom()));
    run_to_end_bytes();
    write_count(8'd255);
    run_to_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int stop_at;
    int pick;
    stop_at = n_busy_words + RandomWords;
    while (n_busy_words < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) write_count(8'd0);
        else if (pick <= 6) write_count(8'($urandom_range(1, 3)));
        else if (pick <= 8) write_count(8'($urandom_range(4, 8)));
        else write_count(8'($urandom_range(9, 17)));
      end
      if ($urandom_range(0, 5) == 0)
        send_word(OP_REQUEST, $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);
      else
        send_word(OP_REQUEST, 24'($urandom()));
      while (ph != PH_IDLE) begin
        pick = $urandom_range(0, 299);
        if (pick < 10) send_word(OP_REQUEST, 24'($urandom()));
        else if (pick == 10) write_count(8'($urandom_range(0, 6)));
        else if (pick == 11) drain();
        else send_tick();
      end
      run_ticks($urandom_range(0, 3));
    end
  endtask

  initial begin : stimulus
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    action_i    <= OP_TICK;
    red_i       <= '0;
    green_i     <= '0;
    blue_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    n_errors     = 0;
    n_busy_words = 0;
    gaps_on      = 1'b1;
    ph           = PH_IDLE;
    led_idx      = '0;
    byte_idx     = '0;
    bit_idx      = '0;
    half         = 1'b0;
    held         = '0;
    clk_lvl      = 1'b1;
    dat_lvl      = 1'b1;
    led_count_q  = CountReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_ticks();
    test_start_only();
    test_colour_extremes();
    test_busy_request();
    test_count_change_midframe();
    test_end_byte_counts();
    test_top_count();
    test_random_frames();

    drain();
    repeat (8) @(posedge clk_i);
    if (line_q.size() != 0) flag($sformatf("%0d result words never arrived", line_q.size()));
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
